/* hdl/cst_pkg.sv */
`timescale 1ns / 1ps

package cst_pkg;

  // Link phases of the tunnel host.
  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_CREDIT = 2'd1,
    PH_NORMAL = 2'd2
  } phase_t;

  // Action codes carried by an input item.
  localparam logic ACT_QUERY   = 1'b0;
  localparam logic ACT_CONFIRM = 1'b1;

  // Header bytes of puts.
  localparam logic [7:0] MARK_START = 8'hAA;
  localparam logic [7:0] MARK_DATA  = 8'hBB;

  // Frame limit handling.
  localparam logic [7:0] LIMIT_RESET = 8'd32;
  localparam logic [7:0] LIMIT_MIN   = 8'd2;

  // Credit bookkeeping held between items.
  typedef struct packed {
    phase_t     phase;
    logic [3:0] pending;
    logic [3:0] space;
  } tunnel_state_t;

  // One input item.
  typedef struct packed {
    logic       action;
    logic [7:0] local_available;
    logic       transfer_complete;
    logic       confirmed_was_get;
    logic [7:0] confirmed_size;
    logic [7:0] confirmed_first_byte;
    logic       local_accepts;
  } item_t;

  // One result item.
  typedef struct packed {
    logic       request_valid;
    logic       request_is_get;
    logic [7:0] request_size;
    logic [7:0] put_marker;
    logic [7:0] take_from_local;
    logic [7:0] deliver_to_local;
    logic       protocol_error;
  } result_t;

endpackage

/* hdl/credit_serial_tunnel.sv */
`timescale 1ns / 1ps
// Two register stages (input, then result) lie between an item and its result.
// Throughput: one item per cycle while the receiver does not stall; the credit
// state is updated in the same cycle that the item moves from the input
// register into the result register.
// Reset (synchronous, active low): empty pipeline, start phase, zero credits,
// frame limit 32.

module credit_serial_tunnel
  import cst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_action,
  input  logic [7:0] in_local_available,
  input  logic       in_transfer_complete,
  input  logic       in_confirmed_was_get,
  input  logic [7:0] in_confirmed_size,
  input  logic [7:0] in_confirmed_first_byte,
  input  logic       in_local_accepts,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_request_valid,
  output logic       out_request_is_get,
  output logic [7:0] out_request_size,
  output logic [7:0] out_put_marker,
  output logic [7:0] out_take_from_local,
  output logic [7:0] out_deliver_to_local,
  output logic       out_protocol_error
);

  logic          in_valid_r;
  item_t         item_r;
  logic          out_valid_r;
  result_t       res_r;
  result_t       res_nxt;
  tunnel_state_t state_r;
  tunnel_state_t state_nxt;
  logic [7:0]    limit_r;
  logic          advance;
  logic          out_load;

  // The item in the input register moves on when the result register is empty or its result is being taken.
  assign advance  = !out_valid_r || !out_stall;
  assign out_load = advance && in_valid_r;
  assign in_stall = in_valid_r && !advance;

  // Frame limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= '{action:               in_action,
                  local_available:      in_local_available,
                  transfer_complete:    in_transfer_complete,
                  confirmed_was_get:    in_confirmed_was_get,
                  confirmed_size:       in_confirmed_size,
                  confirmed_first_byte: in_confirmed_first_byte,
                  local_accepts:        in_local_accepts};
    end
  end

  // Transaction decision and credit update.
  cst_step u_step (
    .state_i       (state_r),
    .item_i        (item_r),
    .frame_limit_i (limit_r),
    .state_nxt     (state_nxt),
    .res_o         (res_nxt)
  );

  // Credit state and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '{phase: PH_START, pending: 4'd0, space: 4'd0};
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        state_r <= state_nxt;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_request_valid    = res_r.request_valid;
  assign out_request_is_get   = res_r.request_is_get;
  assign out_request_size     = res_r.request_size;
  assign out_put_marker       = res_r.put_marker;
  assign out_take_from_local  = res_r.take_from_local;
  assign out_deliver_to_local = res_r.deliver_to_local;
  assign out_protocol_error   = res_r.protocol_error;

  // A reported error leaves the link in its start state with no credits.
  a_error_resets: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && res_nxt.protocol_error |=>
      state_r.phase == PH_START && state_r.pending == 4'd0 && state_r.space == 4'd0)
    else $error("error did not reset the credit state");

  // A data put carries its header byte plus the bytes taken from the local port.
  a_put_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.request_valid && !res_r.request_is_get
      && res_r.put_marker == MARK_DATA |->
      res_r.request_size == res_r.take_from_local + 8'd1)
    else $error("data put size does not match its payload");

  // No transaction exceeds the effective frame limit.
  a_size_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.request_valid |->
      res_r.request_size <= ((limit_r < LIMIT_MIN) ? LIMIT_MIN : limit_r))
    else $error("transaction exceeds the frame limit");

endmodule

/* hdl/cst_step.sv */
`timescale 1ns / 1ps

module cst_step
  import cst_pkg::*;
(
  input  tunnel_state_t state_i,
  input  item_t         item_i,
  input  logic [7:0]    frame_limit_i,
  output tunnel_state_t state_nxt,
  output result_t       res_o
);

  logic [7:0] lim;
  logic [7:0] lim_m1;
  logic [7:0] pend_inc;
  logic [7:0] get_n;
  logic [7:0] get_payload;
  logic [7:0] space_ext;
  logic [7:0] put_a;
  logic [7:0] put_n;
  logic       ok;

  // Effective frame limit; anything below two acts as two.
  assign lim    = (frame_limit_i < LIMIT_MIN) ? LIMIT_MIN : frame_limit_i;
  assign lim_m1 = lim - 8'd1;

  // Capped get size: pending bytes plus the count byte.
  assign pend_inc    = {4'd0, state_i.pending} + 8'd1;
  assign get_n       = (pend_inc > lim) ? lim : pend_inc;
  assign get_payload = get_n - 8'd1;

  // Capped put payload: local bytes, bounded by remote space and frame room.
  assign space_ext = {4'd0, state_i.space};
  assign put_a     = (item_i.local_available > space_ext) ? space_ext
                                                          : item_i.local_available;
  assign put_n     = (put_a > lim_m1) ? lim_m1 : put_a;

  // Decide the transaction for a query, or check a confirmation.
  always_comb begin
    state_nxt = state_i;
    res_o     = '0;
    ok        = 1'b1;
    if (item_i.action == ACT_QUERY) begin
      unique case (state_i.phase)
        PH_START: begin
          res_o.request_valid = 1'b1;
          res_o.request_size  = 8'd1;
          res_o.put_marker    = MARK_START;
        end
        PH_CREDIT: begin
          res_o.request_valid  = 1'b1;
          res_o.request_is_get = 1'b1;
          res_o.request_size   = 8'd1;
        end
        PH_NORMAL: begin
          res_o.request_valid = 1'b1;
          if (state_i.pending != 4'd0) begin
            res_o.request_is_get = 1'b1;
            res_o.request_size   = get_n;
            state_nxt.pending    = state_i.pending - get_payload[3:0];
          end else if (item_i.local_available != 8'd0 && state_i.space != 4'd0) begin
            res_o.request_size    = put_n + 8'd1;
            res_o.put_marker      = MARK_DATA;
            res_o.take_from_local = put_n;
            state_nxt.space       = state_i.space - put_n[3:0];
          end else begin
            // Nothing to move: poll the credit word again.
            res_o.request_is_get = 1'b1;
            res_o.request_size   = 8'd1;
            state_nxt.phase      = PH_CREDIT;
          end
        end
        default: begin
        end
      endcase
    end else begin
      ok = 1'b0;
      if (item_i.transfer_complete) begin
        unique case (state_i.phase)
          PH_START: begin
            if (!item_i.confirmed_was_get) begin
              state_nxt.phase = PH_CREDIT;
              ok              = 1'b1;
            end
          end
          PH_CREDIT: begin
            if (item_i.confirmed_was_get && item_i.confirmed_size == 8'd1) begin
              state_nxt.phase   = PH_NORMAL;
              state_nxt.pending = item_i.confirmed_first_byte[3:0];
              state_nxt.space   = item_i.confirmed_first_byte[7:4];
              ok                = 1'b1;
            end
          end
          PH_NORMAL: begin
            if (!item_i.confirmed_was_get) begin
              ok = 1'b1;
            end else if (item_i.confirmed_size != 8'd0 && item_i.local_accepts) begin
              state_nxt.pending      = item_i.confirmed_first_byte[3:0];
              state_nxt.space        = item_i.confirmed_first_byte[7:4];
              res_o.deliver_to_local = item_i.confirmed_size - 8'd1;
              ok                     = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      // Any mismatch drops the link back to its start state.
      if (!ok) begin
        state_nxt.phase      = PH_START;
        state_nxt.pending    = 4'd0;
        state_nxt.space      = 4'd0;
        res_o.protocol_error = 1'b1;
      end
    end
  end

endmodule

/* verif/credit_serial_tunnel_tb.sv */
`timescale 1ns / 1ps

module credit_serial_tunnel_tb
  import cst_pkg::*;
();

  localparam int RUN_LIMIT_NS = 5_000_000;
  localparam int MAX_REPORTS = 30;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  logic       in_valid;
  logic       in_stall;
  logic       in_action;
  logic [7:0] in_local_available;
  logic       in_transfer_complete;
  logic       in_confirmed_was_get;
  logic [7:0] in_confirmed_size;
  logic [7:0] in_confirmed_first_byte;
  logic       in_local_accepts;
  logic       out_valid;
  logic       out_stall;
  logic       out_request_valid;
  logic       out_request_is_get;
  logic [7:0] out_request_size;
  logic [7:0] out_put_marker;
  logic [7:0] out_take_from_local;
  logic [7:0] out_deliver_to_local;
  logic       out_protocol_error;

  // Local copy of the link bookkeeping, advanced as items are accepted.
  phase_t     link_phase = PH_START;
  logic [3:0] held_remote = 4'd0;
  logic [3:0] room_remote = 4'd0;
  logic [7:0] frame_limit_set = LIMIT_RESET;

  // Replies still owed by the block, oldest first.
  result_t awaited_replies[$];
  result_t last_request;
  logic    last_was_request = 1'b0;

  int error_count = 0;
  bit send_idle_on = 1'b1;
  bit stall_on = 1'b1;
  int hold_off_left = 0;

  credit_serial_tunnel dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_wr_en               (cfg_wr_en),
    .cfg_wr_data             (cfg_wr_data),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_action               (in_action),
    .in_local_available      (in_local_available),
    .in_transfer_complete    (in_transfer_complete),
    .in_confirmed_was_get    (in_confirmed_was_get),
    .in_confirmed_size       (in_confirmed_size),
    .in_confirmed_first_byte (in_confirmed_first_byte),
    .in_local_accepts        (in_local_accepts),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_request_valid       (out_request_valid),
    .out_request_is_get      (out_request_is_get),
    .out_request_size        (out_request_size),
    .out_put_marker          (out_put_marker),
    .out_take_from_local     (out_take_from_local),
    .out_deliver_to_local    (out_deliver_to_local),
    .out_protocol_error      (out_protocol_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decides the reply to one item and moves the link bookkeeping along.
  function automatic result_t advance_tunnel(input item_t it);
    result_t    r;
    logic [7:0] lim;
    logic [7:0] n;
    logic [7:0] used;
    logic       ok;
    r = '0;
    ok = 1'b0;
    lim = (frame_limit_set < LIMIT_MIN) ? LIMIT_MIN : frame_limit_set;
    if (it.action == ACT_QUERY) begin
      case (link_phase)
        PH_START: begin
          r.request_valid = 1'b1;
          r.request_size = 8'd1;
          r.put_marker = MARK_START;
        end
        PH_CREDIT: begin
          r.request_valid = 1'b1;
          r.request_is_get = 1'b1;
          r.request_size = 8'd1;
        end
        PH_NORMAL: begin
          r.request_valid = 1'b1;
          if (held_remote != 4'd0) begin
            // Fetch what the remote holds, capped by the frame limit.
            n = {4'd0, held_remote} + 8'd1;
            if (n > lim) n = lim;
            used = n - 8'd1;
            held_remote = held_remote - used[3:0];
            r.request_is_get = 1'b1;
            r.request_size = n;
          end else if (it.local_available != 8'd0 && room_remote != 4'd0) begin
            // Send local bytes into the remote free space.
            n = it.local_available;
            if (n > {4'd0, room_remote}) n = {4'd0, room_remote};
            if (n > lim - 8'd1) n = lim - 8'd1;
            room_remote = room_remote - n[3:0];
            r.request_size = n + 8'd1;
            r.put_marker = MARK_DATA;
            r.take_from_local = n;
          end else begin
            // Nothing to move: poll the credit word again.
            link_phase = PH_CREDIT;
            r.request_is_get = 1'b1;
            r.request_size = 8'd1;
          end
        end
        default: ;
      endcase
    end else begin
      if (it.transfer_complete) begin
        case (link_phase)
          PH_START: begin
            if (!it.confirmed_was_get) begin
              link_phase = PH_CREDIT;
              ok = 1'b1;
            end
          end
          PH_CREDIT: begin
            if (it.confirmed_was_get && it.confirmed_size == 8'd1) begin
              held_remote = it.confirmed_first_byte[3:0];
              room_remote = it.confirmed_first_byte[7:4];
              link_phase = PH_NORMAL;
              ok = 1'b1;
            end
          end
          PH_NORMAL: begin
            if (!it.confirmed_was_get) begin
              ok = 1'b1;
            end else if (it.confirmed_size != 8'd0) begin
              held_remote = it.confirmed_first_byte[3:0];
              room_remote = it.confirmed_first_byte[7:4];
              if (it.local_accepts) begin
                r.deliver_to_local = it.confirmed_size - 8'd1;
                ok = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      if (!ok) begin
        link_phase = PH_START;
        held_remote = 4'd0;
        room_remote = 4'd0;
        r.protocol_error = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  task automatic check_field(input string field, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
  endtask

  // Length of one idle stretch: mostly short, now and then long.
  function automatic int idle_length();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one item, waits until the block takes it, then books its reply.
  task automatic send_item(input item_t it);
    int gap;
    gap = (send_idle_on && $urandom_range(99) < 40) ? idle_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= it.action;
    in_local_available <= it.local_available;
    in_transfer_complete <= it.transfer_complete;
    in_confirmed_was_get <= it.confirmed_was_get;
    in_confirmed_size <= it.confirmed_size;
    in_confirmed_first_byte <= it.confirmed_first_byte;
    in_local_accepts <= it.local_accepts;
    do @(posedge clk); while (in_stall);
    last_request = advance_tunnel(it);
    last_was_request = (it.action == ACT_QUERY) && last_request.request_valid;
    awaited_replies.push_back(last_request);
  endtask

  task automatic query(input logic [7:0] avail);
    item_t it;
    it = '0;
    it.action = ACT_QUERY;
    it.local_available = avail;
    send_item(it);
  endtask

  task automatic confirm(input logic done, input logic was_get, input logic [7:0] size,
                         input logic [7:0] first, input logic accepts);
    item_t it;
    it = '0;
    it.action = ACT_CONFIRM;
    it.transfer_complete = done;
    it.confirmed_was_get = was_get;
    it.confirmed_size = size;
    it.confirmed_first_byte = first;
    it.local_accepts = accepts;
    send_item(it);
  endtask

  // Lets every reply come back and the pipeline empty.
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_frame_limit(input logic [7:0] value);
    wait_until_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    frame_limit_set = value;
  endtask

  // Mostly proper query and confirm pairs with random credit words, plus
  // some spoiled confirmations and some items with every field random.
  task automatic run_sessions(input int count, input int noise_pct);
    item_t it;
    for (int k = 0; k < count; k++) begin
      it = '0;
      it.local_available = 8'($urandom_range(255));
      if ($urandom_range(99) < noise_pct) begin
        it.action = 1'($urandom_range(1));
        it.transfer_complete = 1'($urandom_range(1));
        it.confirmed_was_get = 1'($urandom_range(1));
        it.confirmed_size = 8'($urandom_range(255));
        it.confirmed_first_byte = 8'($urandom_range(255));
        it.local_accepts = 1'($urandom_range(1));
      end else if (last_was_request) begin
        it.action = ACT_CONFIRM;
        it.transfer_complete = 1'b1;
        it.confirmed_was_get = last_request.request_is_get;
        it.confirmed_size = last_request.request_size;
        if ($urandom_range(99) < 20)
          it.confirmed_size = 8'($urandom_range(1, last_request.request_size));
        it.confirmed_first_byte = 8'($urandom_range(255));
        it.local_accepts = 1'b1;
        if ($urandom_range(99) < 8) begin
          case ($urandom_range(3))
            0: it.transfer_complete = 1'b0;
            1: it.confirmed_was_get = ~it.confirmed_was_get;
            2: it.confirmed_size = 8'd0;
            default: it.local_accepts = 1'b0;
          endcase
        end
      end else begin
        it.action = ACT_QUERY;
        case ($urandom_range(9))
          0, 1, 2: it.local_available = 8'd0;
          3, 4, 5, 6, 7: it.local_available = 8'($urandom_range(1, 15));
          default: it.local_available = 8'($urandom_range(16, 255));
        endcase
      end
      send_item(it);
    end
  endtask

  // Opening, credit read, gets, puts, polling and several ways a confirm fails.
  task automatic test_protocol_walk();
    query(8'd0);
    confirm(1'b1, 1'b0, 8'd1, 8'h00, 1'b1);
    query(8'd255);
    confirm(1'b1, 1'b1, 8'd1, 8'hF0, 1'b1);
    query(8'd255);
    confirm(1'b1, 1'b0, 8'd16, 8'h00, 1'b0);
    query(8'd0);
    confirm(1'b1, 1'b1, 8'd1, 8'h0F, 1'b1);
    query(8'd0);
    confirm(1'b1, 1'b1, 8'd16, 8'hFF, 1'b1);
    query(8'd200);
    // A get confirmed with no bytes is an error.
    confirm(1'b1, 1'b1, 8'd0, 8'h55, 1'b1);
    query(8'd0);
    // The opening put confirmed as a get.
    confirm(1'b1, 1'b1, 8'd1, 8'h00, 1'b1);
    query(8'd0);
    // The link did not report completion.
    confirm(1'b0, 1'b0, 8'd1, 8'h00, 1'b1);
    query(8'd0);
    confirm(1'b1, 1'b0, 8'd1, 8'h00, 1'b1);
    query(8'd0);
    // The credit read came back with the wrong size.
    confirm(1'b1, 1'b1, 8'd2, 8'h33, 1'b1);
    query(8'd0);
    confirm(1'b1, 1'b0, 8'd1, 8'h00, 1'b1);
    query(8'd0);
    confirm(1'b1, 1'b1, 8'd1, 8'h22, 1'b1);
    query(8'd1);
    // The local port refused the delivered bytes.
    confirm(1'b1, 1'b1, 8'd3, 8'h01, 1'b0);
  endtask

  // Frame limits at both ends, and values below two that act as two.
  task automatic test_frame_limits();
    logic [7:0] limits[7] = '{8'd255, 8'd2, 8'd0, 8'd1, 8'd3, 8'd16, 8'd17};
    foreach (limits[i]) begin
      set_frame_limit(limits[i]);
      run_sessions(22, 5);
    end
  endtask

  task automatic test_random_traffic();
    for (int round = 0; round < 4; round++) begin
      set_frame_limit(($urandom_range(1)) ? 8'($urandom_range(2, 20))
                                          : 8'($urandom_range(2, 255)));
      run_sessions(80, 15);
    end
  endtask

  // The receiver holds off for a long time while items keep coming.
  task automatic test_receiver_hold_off();
    send_idle_on = 1'b0;
    stall_on = 1'b0;
    hold_off_left = 150;
    run_sessions(40, 5);
    send_idle_on = 1'b1;
    stall_on = 1'b1;
  endtask

  task automatic test_back_to_back();
    send_idle_on = 1'b0;
    stall_on = 1'b0;
    run_sessions(40, 10);
    send_idle_on = 1'b1;
    stall_on = 1'b1;
  endtask

  // Receiver side: random stalls, and the long hold-off when one is asked.
  initial begin
    int stall_run;
    stall_run = 0;
    forever begin
      @(posedge clk);
      if (hold_off_left > 0) begin
        out_stall <= 1'b1;
        hold_off_left--;
      end else if (stall_run > 0) begin
        out_stall <= 1'b1;
        stall_run--;
      end else if (stall_on && $urandom_range(99) < 25) begin
        out_stall <= 1'b1;
        stall_run = idle_length() - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Every reply taken by the receiver is held against the oldest one owed.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_replies.size() == 0) begin
        report_mismatch("reply with none owed");
      end else begin
        want = awaited_replies.pop_front();
        check_field("request_valid", {7'd0, out_request_valid}, {7'd0, want.request_valid});
        check_field("request_is_get", {7'd0, out_request_is_get},
                    {7'd0, want.request_is_get});
        check_field("request_size", out_request_size, want.request_size);
        check_field("put_marker", out_put_marker, want.put_marker);
        check_field("take_from_local", out_take_from_local, want.take_from_local);
        check_field("deliver_to_local", out_deliver_to_local, want.deliver_to_local);
        check_field("protocol_error", {7'd0, out_protocol_error},
                    {7'd0, want.protocol_error});
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("** credit_serial_tunnel: FAILED **");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 8'd0;
    in_valid = 1'b0;
    in_action = ACT_QUERY;
    in_local_available = 8'd0;
    in_transfer_complete = 1'b0;
    in_confirmed_was_get = 1'b0;
    in_confirmed_size = 8'd0;
    in_confirmed_first_byte = 8'd0;
    in_local_accepts = 1'b0;
    out_stall = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_protocol_walk();
    test_frame_limits();
    test_random_traffic();
    test_receiver_hold_off();
    test_back_to_back();

    wait_until_idle();
    repeat (6) @(posedge clk);
    if (error_count == 0) begin
      $display("** credit_serial_tunnel: PASSED **");
    end else begin
      $display("** credit_serial_tunnel: FAILED **");
    end
    $finish;
  end

endmodule
